FILE: rtl/core/assert_macros.svh
// assertion macros shared by the decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AAD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
`define AAD_NEVER(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(prop)) \
        else $error("forbidden condition seen");
`else
`define AAD_ASSERT(lbl, clk, rstn, prop)
`define AAD_NEVER(lbl, clk, rstn, prop)
`endif
`endif

FILE: rtl/core/aad_pkg.sv
// shared constants, types and control structs of the arithmetic decoder
package aad_pkg;

    localparam int WIN_BITS    = 32;
    localparam int ALPHABET    = 257;
    localparam int COUNT_BITS  = 24;
    localparam int RESULTS_MAX = 64;

    localparam int SYM_W  = $clog2(ALPHABET);
    localparam int N_W    = $clog2(RESULTS_MAX + 1);
    localparam int FILL_W = $clog2(WIN_BITS + 1);
    localparam int BITS_W = 4;
    localparam int MA_W   = WIN_BITS + 1;
    localparam int MB_W   = COUNT_BITS + 1;
    localparam int PROD_W = MA_W + MB_W;
    localparam int CNT_W  = $clog2(PROD_W);

    localparam logic [SYM_W-1:0] END_SYM = SYM_W'(ALPHABET - 1);

    localparam longint LIM_A = (64'd1 << COUNT_BITS) - 64'd1;
    localparam longint LIM_B = 64'd1 << (WIN_BITS - 2);
    localparam logic [COUNT_BITS:0] COUNT_LIMIT =
        (COUNT_BITS + 1)'((LIM_A < LIM_B) ? LIM_A : LIM_B);

    typedef enum logic [1:0] {
        MD_VALUE = 2'd0,
        MD_LOW   = 2'd1,
        MD_HIGH  = 2'd2
    } md_sel_t;

    typedef struct packed {
        logic    accept;
        logic    take_fill;
        logic    take_shift;
        logic    take_e3;
        logic    pend_clr;
        logic    md_start;
        md_sel_t md_sel;
        logic    save_val;
        logic    save_lo;
        logic    srch_start;
        logic    srch_step;
        logic    commit;
        logic    emit;
        logic    flush;
        logic    flush_wc;
    } cmd_t;

    typedef struct packed {
        logic clr_busy;
        logic halted;
        logic fill_done;
        logic bits_empty;
        logic pending;
        logic top_match;
        logic small_range;
        logic md_done;
        logic found;
        logic is_end;
        logic hold_valid;
        logic out_free;
    } sts_t;

endpackage

FILE: rtl/core/aad_mdu.sv
// sequential multiply then divide unit: q = (a * b - sub) / d
module aad_mdu (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [aad_pkg::MA_W-1:0]    a,
    input  logic [aad_pkg::MB_W-1:0]    b,
    input  logic [aad_pkg::MA_W-1:0]    d,
    input  logic                        sub,
    output logic                        done,
    output logic [aad_pkg::PROD_W-1:0]  q
);
    typedef enum logic [2:0] {
        MD_ST_IDLE = 3'b001,
        MD_ST_MUL  = 3'b010,
        MD_ST_DIV  = 3'b100
    } mdu_state_t;

    mdu_state_t                     state_reg;
    logic [aad_pkg::MA_W-1:0]       a_reg;
    logic [aad_pkg::MB_W-1:0]       b_reg;
    logic [aad_pkg::MA_W-1:0]       d_reg;
    logic                           sub_reg;
    logic [aad_pkg::PROD_W-1:0]     acc_reg;
    logic [aad_pkg::MA_W-1:0]       rem_reg;
    logic [aad_pkg::CNT_W-1:0]      cnt_reg;
    logic                           done_reg;

    logic [aad_pkg::PROD_W-1:0]     mul_next;
    logic [aad_pkg::MA_W:0]         trial;
    logic                           ge;
    logic [aad_pkg::MA_W-1:0]       rem_next;

    always_comb begin
        mul_next = {acc_reg[aad_pkg::PROD_W-2:0], 1'b0}
                 + (b_reg[aad_pkg::MB_W-1] ? aad_pkg::PROD_W'(a_reg) : '0);
        trial    = {rem_reg, acc_reg[aad_pkg::PROD_W-1]};
        ge       = trial >= {1'b0, d_reg};
        rem_next = ge ? aad_pkg::MA_W'(trial - {1'b0, d_reg}) : trial[aad_pkg::MA_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MD_ST_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                MD_ST_IDLE: begin
                    if (start) begin
                        a_reg     <= a;
                        b_reg     <= b;
                        d_reg     <= d;
                        sub_reg   <= sub;
                        acc_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= MD_ST_MUL;
                    end
                end
                MD_ST_MUL: begin
                    b_reg <= {b_reg[aad_pkg::MB_W-2:0], 1'b0};
                    if (cnt_reg == aad_pkg::CNT_W'(aad_pkg::MB_W - 1)) begin
                        acc_reg   <= mul_next - aad_pkg::PROD_W'(sub_reg);
                        cnt_reg   <= '0;
                        rem_reg   <= '0;
                        state_reg <= MD_ST_DIV;
                    end else begin
                        acc_reg <= mul_next;
                        cnt_reg <= cnt_reg + aad_pkg::CNT_W'(1);
                    end
                end
                MD_ST_DIV: begin
                    acc_reg <= {acc_reg[aad_pkg::PROD_W-2:0], ge};
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg + aad_pkg::CNT_W'(1);
                    if (cnt_reg == aad_pkg::CNT_W'(aad_pkg::PROD_W - 1)) begin
                        state_reg <= MD_ST_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default: state_reg <= MD_ST_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign q    = acc_reg;
endmodule

FILE: rtl/core/aad_datapath.sv
// decoder datapath: bounds, code window, count table, search and result registers
`include "assert_macros.svh"
module aad_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_kind,
    input  logic [7:0]          s_code_byte,
    input  aad_pkg::cmd_t       cmd,
    output aad_pkg::sts_t       sts,
    input  logic                m_ready,
    output logic                m_valid,
    output logic [7:0]          m_symbol,
    output logic                m_end_of_stream,
    output logic                m_overflow,
    output logic                m_wants_continue,
    output logic                m_last
);
    localparam int W  = aad_pkg::WIN_BITS;
    localparam int CB = aad_pkg::COUNT_BITS;

    logic [W-1:0]                   low_reg, high_reg, win_reg, qlo_reg;
    logic [7:0]                     buf_reg;
    logic [aad_pkg::BITS_W-1:0]     bits_reg;
    logic [aad_pkg::FILL_W-1:0]     fill_reg;
    logic                           halted_reg, pend_reg;
    logic [CB-1:0]                  total_reg, cum_reg, c_reg;
    logic [aad_pkg::SYM_W-1:0]      s_reg, clr_idx_reg;
    logic                           clr_busy_reg;
    logic [aad_pkg::PROD_W-1:0]     value_reg;

    logic [CB-1:0]                  cnt_mem [aad_pkg::ALPHABET];
    logic [CB-1:0]                  mem_q;
    logic [aad_pkg::SYM_W-1:0]      rd_addr, wr_addr;
    logic [CB-1:0]                  wr_data;
    logic                           wr_en;

    logic                           hold_valid_reg, hold_eos_reg, hold_ovf_reg;
    logic [7:0]                     hold_sym_reg;
    logic                           m_valid_reg, m_eos_reg, m_ovf_reg, m_wc_reg, m_last_reg;
    logic [7:0]                     m_sym_reg;

    logic [2:0]                     bit_pos;
    logic                           cur_bit;
    logic [aad_pkg::MA_W-1:0]       range, off;
    logic [aad_pkg::MB_W-1:0]       cum_c_srch, cum_c_hold;
    logic                           found, is_end, ovf_now, out_free, push;
    logic [W-1:0]                   high_sh, low_sh, win_sh;

    logic [aad_pkg::MA_W-1:0]       md_a, md_d;
    logic [aad_pkg::MB_W-1:0]       md_b;
    logic                           md_sub, md_done;
    logic [aad_pkg::PROD_W-1:0]     md_q;

    always_comb begin
        bit_pos    = 3'(4'd8 - bits_reg);
        cur_bit    = buf_reg[bit_pos];
        range      = aad_pkg::MA_W'(high_reg - low_reg) + aad_pkg::MA_W'(1);
        off        = aad_pkg::MA_W'(win_reg - low_reg) + aad_pkg::MA_W'(1);
        cum_c_srch = aad_pkg::MB_W'(cum_reg) + aad_pkg::MB_W'(mem_q);
        cum_c_hold = aad_pkg::MB_W'(cum_reg) + aad_pkg::MB_W'(c_reg);
        is_end     = s_reg == aad_pkg::END_SYM;
        found      = (value_reg < aad_pkg::PROD_W'(cum_c_srch)) || is_end;
        ovf_now    = {1'b0, total_reg} >= aad_pkg::COUNT_LIMIT;
        out_free   = !m_valid_reg || m_ready;
        push       = (cmd.emit && hold_valid_reg) || cmd.flush;

        high_sh = {high_reg[W-2:0], 1'b1};
        low_sh  = {low_reg[W-2:0], 1'b0};
        win_sh  = {win_reg[W-2:0], cur_bit};
        if (cmd.take_e3) begin
            high_sh[W-1] = 1'b1;
            low_sh[W-1]  = 1'b0;
            win_sh[W-1]  = ~win_sh[W-1];
        end
    end

    always_comb begin
        md_a   = range;
        md_b   = aad_pkg::MB_W'(total_reg);
        md_d   = range;
        md_sub = 1'b0;
        unique case (cmd.md_sel)
            aad_pkg::MD_VALUE: begin
                md_a   = off;
                md_b   = aad_pkg::MB_W'(total_reg);
                md_d   = range;
                md_sub = 1'b1;
            end
            aad_pkg::MD_LOW: begin
                md_b = aad_pkg::MB_W'(cum_reg);
                md_d = aad_pkg::MA_W'(total_reg);
            end
            aad_pkg::MD_HIGH: begin
                md_b = cum_c_hold;
                md_d = aad_pkg::MA_W'(total_reg);
            end
            default: md_sub = 1'b1;
        endcase
    end

    aad_mdu u_mdu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.md_start),
        .a       (md_a),
        .b       (md_b),
        .d       (md_d),
        .sub     (md_sub),
        .done    (md_done),
        .q       (md_q)
    );

    // count table port selection
    always_comb begin
        wr_en   = clr_busy_reg || cmd.commit;
        wr_addr = clr_busy_reg ? clr_idx_reg : s_reg;
        wr_data = clr_busy_reg ? CB'(1) : c_reg + CB'(1);
        if (cmd.srch_start) begin
            rd_addr = '0;
        end else if (cmd.srch_step && !found) begin
            rd_addr = s_reg + aad_pkg::SYM_W'(1);
        end else begin
            rd_addr = s_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cnt_mem[wr_addr] <= wr_data;
        end
        mem_q <= cnt_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg        <= '0;
            high_reg       <= '1;
            win_reg        <= '0;
            buf_reg        <= '0;
            bits_reg       <= '0;
            fill_reg       <= '0;
            halted_reg     <= 1'b0;
            pend_reg       <= 1'b0;
            total_reg      <= CB'(aad_pkg::ALPHABET);
            clr_busy_reg   <= 1'b1;
            clr_idx_reg    <= '0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            s_reg          <= '0;
            cum_reg        <= '0;
        end else begin
            if (clr_busy_reg) begin
                clr_idx_reg <= clr_idx_reg + aad_pkg::SYM_W'(1);
                if (clr_idx_reg == aad_pkg::END_SYM) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (cmd.accept && !s_kind) begin
                buf_reg  <= s_code_byte;
                bits_reg <= aad_pkg::BITS_W'(8);
            end
            if (cmd.take_fill) begin
                win_reg  <= win_sh;
                fill_reg <= fill_reg + aad_pkg::FILL_W'(1);
                bits_reg <= bits_reg - aad_pkg::BITS_W'(1);
            end
            if (cmd.take_shift) begin
                high_reg <= high_sh;
                low_reg  <= low_sh;
                win_reg  <= win_sh;
                bits_reg <= bits_reg - aad_pkg::BITS_W'(1);
            end
            if (cmd.pend_clr) begin
                pend_reg <= 1'b0;
            end
            if (cmd.save_val) begin
                value_reg <= md_q;
            end
            if (cmd.save_lo) begin
                qlo_reg <= md_q[W-1:0];
            end
            if (cmd.srch_start) begin
                s_reg   <= '0;
                cum_reg <= '0;
            end else if (cmd.srch_step) begin
                if (found) begin
                    c_reg <= mem_q;
                end else begin
                    s_reg   <= s_reg + aad_pkg::SYM_W'(1);
                    cum_reg <= CB'(cum_c_srch);
                end
            end
            if (cmd.commit) begin
                low_reg   <= low_reg + qlo_reg;
                high_reg  <= low_reg + md_q[W-1:0] - W'(1);
                total_reg <= total_reg + CB'(1);
                pend_reg  <= 1'b1;
            end
            if (cmd.emit) begin
                hold_valid_reg <= 1'b1;
                hold_sym_reg   <= s_reg[7:0];
                hold_eos_reg   <= is_end;
                hold_ovf_reg   <= !is_end && ovf_now;
                if (is_end || ovf_now) begin
                    halted_reg <= 1'b1;
                end
            end
            if (cmd.flush) begin
                hold_valid_reg <= 1'b0;
            end
            if (push) begin
                m_valid_reg <= 1'b1;
                m_sym_reg   <= hold_sym_reg;
                m_eos_reg   <= hold_eos_reg;
                m_ovf_reg   <= hold_ovf_reg;
                m_last_reg  <= cmd.flush;
                m_wc_reg    <= cmd.flush && cmd.flush_wc;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        sts.clr_busy    = clr_busy_reg;
        sts.halted      = halted_reg;
        sts.fill_done   = fill_reg == aad_pkg::FILL_W'(W);
        sts.bits_empty  = bits_reg == '0;
        sts.pending     = pend_reg;
        sts.top_match   = high_reg[W-1] == low_reg[W-1];
        sts.small_range = (high_reg[W-1] != high_reg[W-2]) && (low_reg[W-1] != low_reg[W-2])
                          && (high_reg[W-1] != low_reg[W-1]);
        sts.md_done     = md_done;
        sts.found       = found;
        sts.is_end      = is_end;
        sts.hold_valid  = hold_valid_reg;
        sts.out_free    = out_free;
    end

    assign m_valid          = m_valid_reg;
    assign m_symbol         = m_sym_reg;
    assign m_end_of_stream  = m_eos_reg;
    assign m_overflow       = m_ovf_reg;
    assign m_wants_continue = m_wc_reg;
    assign m_last           = m_last_reg;

    `AAD_ASSERT(a_fill_bound, aclk, aresetn, fill_reg <= aad_pkg::FILL_W'(W))
    `AAD_ASSERT(a_bits_bound, aclk, aresetn, bits_reg <= aad_pkg::BITS_W'(8))
    `AAD_NEVER(a_push_blocked, aclk, aresetn, push && m_valid_reg && !m_ready)
endmodule

FILE: rtl/core/aad_ctrl.sv
// decoder sequencer: steps window fill, renormalization, search and result hand-off
`include "assert_macros.svh"
module aad_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output aad_pkg::cmd_t   cmd,
    input  aad_pkg::sts_t   sts
);
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_STEP  = 8'b0000_0010,
        ST_MDV   = 8'b0000_0100,
        ST_SRCH  = 8'b0000_1000,
        ST_MDL   = 8'b0001_0000,
        ST_MDH   = 8'b0010_0000,
        ST_EMIT  = 8'b0100_0000,
        ST_FLUSH = 8'b1000_0000
    } state_t;

    state_t                     state_reg, state_next;
    logic [aad_pkg::N_W-1:0]    n_reg;
    logic                       wc_reg;
    logic                       set_wc;

    always_comb begin
        cmd        = '0;
        cmd.md_sel = aad_pkg::MD_VALUE;
        cmd.flush_wc = wc_reg;
        state_next = state_reg;
        s_ready    = 1'b0;
        set_wc     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = !sts.clr_busy;
                if (s_valid && !sts.clr_busy) begin
                    cmd.accept = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                if (sts.halted) begin
                    state_next = ST_FLUSH;
                end else if (!sts.fill_done) begin
                    if (sts.bits_empty) begin
                        state_next = ST_FLUSH;
                    end else begin
                        cmd.take_fill = 1'b1;
                    end
                end else if (sts.pending) begin
                    if (sts.top_match || sts.small_range) begin
                        if (sts.bits_empty) begin
                            state_next = ST_FLUSH;
                        end else begin
                            cmd.take_shift = 1'b1;
                            cmd.take_e3    = !sts.top_match;
                        end
                    end else begin
                        cmd.pend_clr = 1'b1;
                    end
                end else if (n_reg >= aad_pkg::N_W'(aad_pkg::RESULTS_MAX)) begin
                    set_wc     = 1'b1;
                    state_next = ST_FLUSH;
                end else begin
                    cmd.md_start = 1'b1;
                    state_next   = ST_MDV;
                end
            end
            ST_MDV: begin
                if (sts.md_done) begin
                    cmd.save_val   = 1'b1;
                    cmd.srch_start = 1'b1;
                    state_next     = ST_SRCH;
                end
            end
            ST_SRCH: begin
                cmd.srch_step = 1'b1;
                if (sts.found) begin
                    if (sts.is_end) begin
                        state_next = ST_EMIT;
                    end else begin
                        cmd.md_start = 1'b1;
                        cmd.md_sel   = aad_pkg::MD_LOW;
                        state_next   = ST_MDL;
                    end
                end
            end
            ST_MDL: begin
                cmd.md_sel = aad_pkg::MD_HIGH;
                if (sts.md_done) begin
                    cmd.save_lo  = 1'b1;
                    cmd.md_start = 1'b1;
                    state_next   = ST_MDH;
                end
            end
            ST_MDH: begin
                cmd.md_sel = aad_pkg::MD_HIGH;
                if (sts.md_done) begin
                    cmd.commit = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!sts.hold_valid || sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_FLUSH: begin
                if (!sts.hold_valid) begin
                    state_next = ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            wc_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.accept) begin
                n_reg  <= '0;
                wc_reg <= 1'b0;
            end else begin
                if (cmd.emit) begin
                    n_reg <= n_reg + aad_pkg::N_W'(1);
                end
                if (set_wc) begin
                    wc_reg <= 1'b1;
                end
            end
        end
    end

    `AAD_ASSERT(a_idle_no_hold, aclk, aresetn, (state_reg == ST_IDLE) |-> !sts.hold_valid)
    `AAD_NEVER(a_emit_halted, aclk, aresetn, cmd.emit && sts.halted)
    `AAD_ASSERT(a_n_bound, aclk, aresetn, n_reg <= aad_pkg::N_W'(aad_pkg::RESULTS_MAX))
endmodule

FILE: rtl/core/adaptive_arithmetic_decoder.sv
// top level of the adaptive arithmetic decoder
//
// Input channel s_*: one item per code byte (s_kind low) or a continue item
// (s_kind high). Bits of a byte are used least significant first. Result
// channel m_*: one item per decoded symbol, m_last on the final result of
// an input item, m_wants_continue when 64 results were given and more wait.
// An input item is taken only when the previous one is fully worked off;
// the last result may still sit in the output register meanwhile.
// Window fill and renormalization use one code bit per step. Each symbol
// but the end symbol costs three multiply/divide passes plus a count
// search that visits table entries one at a time (up to 257); the end
// symbol costs one pass and the search. All passes share the single
// multiply/divide unit.
// Reset: synchronous, active low; afterwards a sweep sets every
// count to one, with s_ready held low. After the end symbol or an overflow
// every item is taken and ignored until the next reset.
// A stalled receiver holds the decoder at its next result hand-off.
module adaptive_arithmetic_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_code_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_symbol,
    output logic        m_end_of_stream,
    output logic        m_overflow,
    output logic        m_wants_continue,
    output logic        m_last
);
    aad_pkg::cmd_t cmd;
    aad_pkg::sts_t sts;

    aad_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    aad_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_kind           (s_kind),
        .s_code_byte      (s_code_byte),
        .cmd              (cmd),
        .sts              (sts),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_symbol         (m_symbol),
        .m_end_of_stream  (m_end_of_stream),
        .m_overflow       (m_overflow),
        .m_wants_continue (m_wants_continue),
        .m_last           (m_last)
    );
endmodule

FILE: tb/sv/tb.sv
// self-checking testbench for the adaptive arithmetic decoder
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] symbol;
        logic       eos;
        logic       ovf;
        logic       wants_cont;
        logic       last;
    } sym_result_t;

    class decode_scoreboard;
        int unsigned     counts[aad_pkg::ALPHABET];
        longint unsigned total, lo_b, hi_b, win, wmask, wtop, wnext;
        logic [7:0]      byte_buf;
        int              left, fill, errors;
        bit              halted, pend;
        sym_result_t     expected_q[$];

        function new();
            wmask = (64'd1 << aad_pkg::WIN_BITS) - 64'd1;
            wtop  = 64'd1 << (aad_pkg::WIN_BITS - 1);
            wnext = 64'd1 << (aad_pkg::WIN_BITS - 2);
            foreach (counts[i]) counts[i] = 1;
            total = aad_pkg::ALPHABET;
            lo_b = 0;
            hi_b = wmask;
            win = 0;
            byte_buf = 0;
            left = 0;
            fill = 0;
            halted = 0;
            pend = 0;
            errors = 0;
        endfunction

        function longint unsigned next_bit();
            int pos;
            pos = (8 - left) & 7;
            left--;
            return (byte_buf >> pos) & 1;
        endfunction

        function void shift_bounds(longint unsigned b);
            hi_b = ((hi_b << 1) | 1) & wmask;
            lo_b = (lo_b << 1) & wmask;
            win = ((win << 1) | b) & wmask;
        endfunction

        function void note_item(logic k, logic [7:0] b);
            sym_result_t     res[$];
            sym_result_t     r;
            int              n, s;
            bit              at_lim, h1, h2, l1, l2;
            longint unsigned rng, off, value, cum, c, lo0;
            n = 0;
            at_lim = 0;
            if (!k) begin
                byte_buf = b;
                left = 8;
            end
            if (halted) return;
            while (1) begin
                if (fill < aad_pkg::WIN_BITS) begin
                    if (left == 0) break;
                    win = ((win << 1) | next_bit()) & wmask;
                    fill++;
                    continue;
                end
                if (pend) begin
                    h1 = (hi_b & wtop) != 0;
                    h2 = (hi_b & wnext) != 0;
                    l1 = (lo_b & wtop) != 0;
                    l2 = (lo_b & wnext) != 0;
                    if (h1 == l1) begin
                        if (left == 0) break;
                        shift_bounds(next_bit());
                    end else if (h1 != h2 && l1 != l2) begin
                        if (left == 0) break;
                        shift_bounds(next_bit());
                        hi_b = hi_b | wtop;
                        lo_b = lo_b & ~wtop;
                        win = win ^ wtop;
                    end else begin
                        pend = 0;
                    end
                    continue;
                end
                if (n >= aad_pkg::RESULTS_MAX) begin
                    at_lim = 1;
                    break;
                end
                rng = ((hi_b - lo_b) & wmask) + 1;
                off = ((win - lo_b) & wmask) + 1;
                value = (off * total - 1) / rng;
                cum = 0;
                s = 0;
                lo0 = lo_b;
                while (1) begin
                    c = counts[s];
                    if (value < cum + c || s == aad_pkg::ALPHABET - 1) break;
                    cum += c;
                    s++;
                end
                r = '0;
                if (s == aad_pkg::ALPHABET - 1) begin
                    r.eos = 1;
                    res.push_back(r);
                    n++;
                    halted = 1;
                    break;
                end
                lo_b = (lo0 + (rng * cum) / total) & wmask;
                hi_b = (lo0 + (rng * (cum + c)) / total - 1) & wmask;
                counts[s]++;
                total++;
                r.symbol = s[7:0];
                if (total >= aad_pkg::COUNT_LIMIT) begin
                    r.ovf = 1;
                    res.push_back(r);
                    n++;
                    halted = 1;
                    break;
                end
                res.push_back(r);
                n++;
                pend = 1;
            end
            if (n > 0) begin
                res[n-1].wants_cont = at_lim;
                res[n-1].last = 1;
            end
            foreach (res[i]) expected_q.push_back(res[i]);
        endfunction

        function void check_result(sym_result_t got);
            sym_result_t exp_r;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.symbol !== exp_r.symbol)
                $display("%0t: symbol exp %0d got %0d", $time, exp_r.symbol, got.symbol);
            if (got.eos !== exp_r.eos)
                $display("%0t: end_of_stream exp %0d got %0d", $time, exp_r.eos, got.eos);
            if (got.ovf !== exp_r.ovf)
                $display("%0t: overflow exp %0d got %0d", $time, exp_r.ovf, got.ovf);
            if (got.wants_cont !== exp_r.wants_cont)
                $display("%0t: wants_continue exp %0d got %0d", $time,
                         exp_r.wants_cont, got.wants_cont);
            if (got.last !== exp_r.last)
                $display("%0t: last exp %0d got %0d", $time, exp_r.last, got.last);
            if (got !== exp_r) errors++;
        endfunction
    endclass

    logic       aclk = 0;
    logic       aresetn = 0;
    logic       s_valid = 0;
    logic       s_ready;
    logic       s_kind = 0;
    logic [7:0] s_code_byte = 0;
    logic       m_valid;
    logic       m_ready = 0;
    logic [7:0] m_symbol;
    logic       m_end_of_stream, m_overflow, m_wants_continue, m_last;

    decode_scoreboard sb = new();
    longint unsigned  cycles = 0;
    bit               quiet = 0;

    adaptive_arithmetic_decoder uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_kind(s_kind), .s_code_byte(s_code_byte),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_symbol(m_symbol), .m_end_of_stream(m_end_of_stream),
        .m_overflow(m_overflow), .m_wants_continue(m_wants_continue),
        .m_last(m_last)
    );

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd100_000_000) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_symbol, m_end_of_stream, m_overflow, m_wants_continue, m_last});
        m_ready <= quiet || ($urandom_range(99) >= 6);
    end

    task send_item(input logic k, input logic [7:0] b);
        if (!quiet && $urandom_range(99) < 6) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1;
        s_kind <= k;
        s_code_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(k, b);
    endtask

    initial begin
        logic [7:0] directed[$];
        logic [7:0] b;
        directed = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hA5, 8'h00, 8'h00, 8'h80,
                     8'h01, 8'h00, 8'h00, 8'h7F, 8'h00, 8'h00, 8'h3C, 8'hFF};
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        foreach (directed[i]) begin
            send_item(0, directed[i]);
            if (i == 6 || i == 12) send_item(1, 8'hFF);
        end
        for (int i = 0; i < 380; i++) begin
            quiet = (i >= 150 && i < 230);
            b = ($urandom_range(99) < 50) ? 8'h00 : 8'($urandom);
            send_item($urandom_range(99) < 15, b);
        end
        s_valid <= 0;
        quiet = 0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (1200) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/aad_pkg.sv
rtl/core/aad_mdu.sv
rtl/core/aad_datapath.sv
rtl/core/aad_ctrl.sv
rtl/core/adaptive_arithmetic_decoder.sv
tb/sv/tb.sv
